// ===== hw/rtl/cdlq_pkg.sv =====
`timescale 1ns / 1ps

package cdlq_pkg;

    // Fixed field widths of the request and result transactions
    localparam int ELEM_W   = 6;
    localparam int QSEL_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Default sizing of the element pool and queue set
    localparam int DEF_NUM_ELEMS  = 64;
    localparam int DEF_NUM_QUEUES = 4;

    // Request opcodes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOT_IN  = 2'd3
    } status_t;

    // Microprogram steps
    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_DISP      = 3'd1,
        S_APP_FIRST = 3'd2,
        S_APP_LINK  = 3'd3,
        S_APP_TAIL  = 3'd4,
        S_REM_CHK   = 3'd5,
        S_REM_LAST  = 3'd6,
        S_REM_LINK  = 3'd7
    } step_t;

    // Next-step mode
    typedef enum logic [1:0] {
        NX_WAIT     = 2'd0,
        NX_SEQ      = 2'd1,
        NX_DISP_REQ = 2'd2,
        NX_DISP_REM = 2'd3
    } nx_mode_t;

    // Read address select for the predecessor link memory
    typedef enum logic [1:0] {
        RA_ELEM   = 2'd0,
        RA_HEAD   = 2'd1,
        RA_BY_CMD = 2'd2
    } prv_ra_t;

    // Successor link writes: target <= data
    typedef enum logic [2:0] {
        WN_NONE   = 3'd0,
        WN_E_SELF = 3'd1,   // nxt[e] <= e
        WN_E_HEAD = 3'd2,   // nxt[e] <= head
        WN_T_E    = 3'd3,   // nxt[tail] <= e
        WN_P_N    = 3'd4    // nxt[p] <= n
    } wr_nxt_t;

    // Predecessor link writes
    typedef enum logic [2:0] {
        WP_NONE   = 3'd0,
        WP_E_SELF = 3'd1,   // prv[e] <= e
        WP_E_T    = 3'd2,   // prv[e] <= tail read
        WP_H_E    = 3'd3,   // prv[head] <= e
        WP_N_P    = 3'd4    // prv[n] <= p
    } wr_prv_t;

    typedef enum logic [1:0] {
        MB_NONE  = 2'd0,
        MB_SET   = 2'd1,
        MB_CLEAR = 2'd2
    } mb_op_t;

    typedef enum logic [1:0] {
        LN_NONE = 2'd0,
        LN_INC  = 2'd1,
        LN_DEC  = 2'd2
    } ln_op_t;

    typedef enum logic [1:0] {
        HD_NONE      = 2'd0,
        HD_ELEM      = 2'd1,
        HD_NEXT_IF_E = 2'd2
    } hd_op_t;

    // One control word of the microprogram
    typedef struct packed {
        nx_mode_t nx;
        step_t    tgt;
        prv_ra_t  prv_ra;
        wr_nxt_t  wr_nxt;
        wr_prv_t  wr_prv;
        logic     wr_own;
        mb_op_t   mb_op;
        ln_op_t   ln_op;
        hd_op_t   hd_op;
        logic     save_t;
    } ctrl_t;

    localparam ctrl_t CW_NOP = '{
        nx:     NX_SEQ,
        tgt:    S_IDLE,
        prv_ra: RA_ELEM,
        wr_nxt: WN_NONE,
        wr_prv: WP_NONE,
        wr_own: 1'b0,
        mb_op:  MB_NONE,
        ln_op:  LN_NONE,
        hd_op:  HD_NONE,
        save_t: 1'b0
    };

    // Microprogram ROM
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t c;
        c = CW_NOP;
        unique case (step)
            S_IDLE:
            begin
                c.nx = NX_WAIT;
            end
            S_DISP:
            begin
                c.nx     = NX_DISP_REQ;
                c.prv_ra = RA_BY_CMD;
            end
            S_APP_FIRST:
            begin
                c.tgt    = S_IDLE;
                c.wr_nxt = WN_E_SELF;
                c.wr_prv = WP_E_SELF;
                c.wr_own = 1'b1;
                c.mb_op  = MB_SET;
                c.ln_op  = LN_INC;
                c.hd_op  = HD_ELEM;
            end
            S_APP_LINK:
            begin
                c.tgt    = S_APP_TAIL;
                c.wr_nxt = WN_E_HEAD;
                c.wr_prv = WP_E_T;
                c.wr_own = 1'b1;
                c.mb_op  = MB_SET;
                c.ln_op  = LN_INC;
                c.save_t = 1'b1;
            end
            S_APP_TAIL:
            begin
                c.tgt    = S_IDLE;
                c.wr_nxt = WN_T_E;
                c.wr_prv = WP_H_E;
            end
            S_REM_CHK:
            begin
                c.nx = NX_DISP_REM;
            end
            S_REM_LAST:
            begin
                c.tgt   = S_IDLE;
                c.mb_op = MB_CLEAR;
                c.ln_op = LN_DEC;
            end
            S_REM_LINK:
            begin
                c.tgt    = S_IDLE;
                c.wr_nxt = WN_P_N;
                c.wr_prv = WP_N_P;
                c.mb_op  = MB_CLEAR;
                c.ln_op  = LN_DEC;
                c.hd_op  = HD_NEXT_IF_E;
            end
            default:
            begin
                c = CW_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/cdlq_if.sv =====
`timescale 1ns / 1ps

// Request channel
interface cdlq_req_if import cdlq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [QSEL_W-1:0] queue_sel;
    logic [ELEM_W-1:0] elem_id;

    modport source (output valid, cmd, queue_sel, elem_id, input ready);
    modport sink   (input valid, cmd, queue_sel, elem_id, output ready);
endinterface

// Result channel
interface cdlq_rsp_if import cdlq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   elem_out;
    logic [COUNT_W-1:0]  queue_count;
    logic [ELEM_W-1:0]   head_out;
    logic                queue_empty;

    modport source (output valid, status, elem_out, queue_count, head_out, queue_empty,
                    input ready);
    modport sink   (input valid, status, elem_out, queue_count, head_out, queue_empty,
                    output ready);
endinterface

// ===== hw/rtl/circular_doubly_linked_queue_core.sv =====
// From request accept to the result register the sequencer goes through S_DISP; a
// request refused at dispatch then returns to S_IDLE, an append to an empty queue
// passes S_APP_FIRST, a tail append S_APP_LINK and S_APP_TAIL; a remove passes
// S_REM_CHK, where the owner check may refuse it, then S_REM_LAST or S_REM_LINK.
// One request in the sequencer at a time; next accepted in the cycle its result loads.
// Reset empties all queues at once (lengths and member flags); links are not reset.
`timescale 1ns / 1ps

module circular_doubly_linked_queue_core import cdlq_pkg::*; #(
    parameter int NUM_ELEMS  = DEF_NUM_ELEMS,
    parameter int NUM_QUEUES = DEF_NUM_QUEUES
) (
    input  logic       clk,
    input  logic       rst_n,
    cdlq_req_if.sink   req,
    cdlq_rsp_if.source rsp
);

    localparam int EW = $clog2(NUM_ELEMS);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(NUM_ELEMS + 1);

    // Sequencer and request registers
    step_t             upc_reg, upc_next;
    status_t           status_reg, status_next;
    logic              cmd_reg;
    logic [QSEL_W-1:0] q_reg;
    logic [ELEM_W-1:0] e_reg;
    logic [EW-1:0]     t_reg;
    logic              res_pend_reg;

    // Queue and element state
    logic [EW-1:0] head_reg   [NUM_QUEUES];
    logic [CW-1:0] len_reg    [NUM_QUEUES];
    logic          member_reg [NUM_ELEMS];

    // Link and owner memories
    logic [EW-1:0] nxt_mem [NUM_ELEMS];
    logic [EW-1:0] prv_mem [NUM_ELEMS];
    logic [QW-1:0] own_mem [NUM_ELEMS];
    logic [EW-1:0] nxt_rd_reg;
    logic [EW-1:0] prv_rd_reg;
    logic [QW-1:0] own_rd_reg;

    // Result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ELEM_W-1:0]   out_elem_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [ELEM_W-1:0]   out_head_reg;
    logic                out_empty_reg;

    ctrl_t         cw;
    logic [EW-1:0] e_idx;
    logic [QW-1:0] q_idx;
    logic          e_ok;
    logic          q_ok;
    logic [CW-1:0] len_q;
    logic [EW-1:0] head_q;
    logic          member_e;
    logic          out_free;
    logic          load_res;
    logic          accept;

    logic          nxt_we;
    logic [EW-1:0] nxt_waddr;
    logic [EW-1:0] nxt_wdata;
    logic          prv_we;
    logic [EW-1:0] prv_waddr;
    logic [EW-1:0] prv_wdata;
    logic [EW-1:0] prv_raddr;

    // Request decode
    assign cw       = ucode_rom(upc_reg);
    assign e_idx    = EW'(e_reg);
    assign q_idx    = QW'(q_reg);
    assign e_ok     = int'(e_reg) < NUM_ELEMS;
    assign q_ok     = int'(q_reg) < NUM_QUEUES;
    assign len_q    = q_ok ? len_reg[q_idx] : '0;
    assign head_q   = q_ok ? head_reg[q_idx] : '0;
    assign member_e = e_ok ? member_reg[e_idx] : 1'b0;

    // Handshakes
    assign out_free  = !out_valid_reg || rsp.ready;
    assign load_res  = (upc_reg == S_IDLE) && res_pend_reg && out_free;
    assign req.ready = (upc_reg == S_IDLE) && (!res_pend_reg || out_free);
    assign accept    = req.valid && req.ready;

    // Next step and status
    always_comb
    begin
        upc_next    = upc_reg;
        status_next = status_reg;
        unique case (cw.nx)
            NX_WAIT:
            begin
                if (accept)
                begin
                    upc_next = S_DISP;
                end
            end
            NX_SEQ:
            begin
                upc_next = cw.tgt;
            end
            NX_DISP_REQ:
            begin
                status_next = ST_OK;
                if (!q_ok)
                begin
                    status_next = ST_EMPTY;
                    upc_next    = S_IDLE;
                end
                else if (cmd_reg == CMD_APPEND)
                begin
                    priority if (!e_ok || member_e)
                    begin
                        status_next = ST_ALREADY;
                        upc_next    = S_IDLE;
                    end
                    else if (len_q == '0)
                    begin
                        upc_next = S_APP_FIRST;
                    end
                    else
                    begin
                        upc_next = S_APP_LINK;
                    end
                end
                else
                begin
                    priority if (len_q == '0)
                    begin
                        status_next = ST_EMPTY;
                        upc_next    = S_IDLE;
                    end
                    else if (!e_ok || !member_e)
                    begin
                        status_next = ST_NOT_IN;
                        upc_next    = S_IDLE;
                    end
                    else
                    begin
                        upc_next = S_REM_CHK;
                    end
                end
            end
            NX_DISP_REM:
            begin
                priority if (own_rd_reg != q_idx)
                begin
                    status_next = ST_NOT_IN;
                    upc_next    = S_IDLE;
                end
                else if (len_q == CW'(1))
                begin
                    upc_next = S_REM_LAST;
                end
                else
                begin
                    upc_next = S_REM_LINK;
                end
            end
            default:
            begin
                upc_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls from the control word
    always_comb
    begin
        nxt_we    = 1'b0;
        nxt_waddr = e_idx;
        nxt_wdata = e_idx;
        unique case (cw.wr_nxt)
            WN_NONE:   nxt_we = 1'b0;
            WN_E_SELF:
            begin
                nxt_we = 1'b1;
            end
            WN_E_HEAD:
            begin
                nxt_we    = 1'b1;
                nxt_wdata = head_q;
            end
            WN_T_E:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = t_reg;
            end
            WN_P_N:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = prv_rd_reg;
                nxt_wdata = nxt_rd_reg;
            end
            default:   nxt_we = 1'b0;
        endcase

        prv_we    = 1'b0;
        prv_waddr = e_idx;
        prv_wdata = e_idx;
        unique case (cw.wr_prv)
            WP_NONE:   prv_we = 1'b0;
            WP_E_SELF:
            begin
                prv_we = 1'b1;
            end
            WP_E_T:
            begin
                prv_we    = 1'b1;
                prv_wdata = prv_rd_reg;
            end
            WP_H_E:
            begin
                prv_we    = 1'b1;
                prv_waddr = head_q;
            end
            WP_N_P:
            begin
                prv_we    = 1'b1;
                prv_waddr = nxt_rd_reg;
                prv_wdata = prv_rd_reg;
            end
            default:   prv_we = 1'b0;
        endcase

        unique case (cw.prv_ra)
            RA_ELEM:   prv_raddr = e_idx;
            RA_HEAD:   prv_raddr = head_q;
            RA_BY_CMD: prv_raddr = (cmd_reg == CMD_REMOVE) ? e_idx : head_q;
            default:   prv_raddr = e_idx;
        endcase
    end

    // Link and owner memories
    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rd_reg <= nxt_mem[e_idx];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        prv_rd_reg <= prv_mem[prv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cw.wr_own)
        begin
            own_mem[e_idx] <= q_idx;
        end
        own_rd_reg <= own_mem[e_idx];
    end

    // Heads and saved tail
    always_ff @(posedge clk)
    begin
        if (cw.save_t)
        begin
            t_reg <= prv_rd_reg;
        end
        if (cw.hd_op == HD_ELEM)
        begin
            head_reg[q_idx] <= e_idx;
        end
        else if (cw.hd_op == HD_NEXT_IF_E && head_q == e_idx)
        begin
            head_reg[q_idx] <= nxt_rd_reg;
        end
    end

    // Lengths and member flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                len_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                member_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cw.ln_op == LN_INC)
            begin
                len_reg[q_idx] <= len_q + CW'(1);
            end
            else if (cw.ln_op == LN_DEC)
            begin
                len_reg[q_idx] <= len_q - CW'(1);
            end
            if (cw.mb_op == MB_SET)
            begin
                member_reg[e_idx] <= 1'b1;
            end
            else if (cw.mb_op == MB_CLEAR)
            begin
                member_reg[e_idx] <= 1'b0;
            end
        end
    end

    // Step counter and pending result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg      <= S_IDLE;
            res_pend_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (accept)
            begin
                res_pend_reg <= 1'b1;
            end
            else if (load_res)
            begin
                res_pend_reg <= 1'b0;
            end
        end
    end

    // Request capture and status
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            cmd_reg <= req.cmd;
            q_reg   <= req.queue_sel;
            e_reg   <= req.elem_id;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_status_reg <= status_reg;
            out_elem_reg   <= e_reg;
            out_count_reg  <= COUNT_W'(len_q);
            out_head_reg   <= (len_q != '0) ? ELEM_W'(head_q) : '0;
            out_empty_reg  <= (len_q == '0);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.elem_out    = out_elem_reg;
    assign rsp.queue_count = out_count_reg;
    assign rsp.head_out    = out_head_reg;
    assign rsp.queue_empty = out_empty_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cdlq_pkg::*;

    localparam int N_ELEMS    = DEF_NUM_ELEMS;
    localparam int N_QUEUES   = DEF_NUM_QUEUES;
    localparam int RAND_OPS   = 1750;
    localparam int STALL_MAX  = 2000;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic              cmd;
        logic [QSEL_W-1:0] qsel;
        logic [ELEM_W-1:0] elem;
    } queue_req_t;

    typedef struct packed {
        status_t            status;
        logic [ELEM_W-1:0]  elem;
        logic [COUNT_W-1:0] count;
        logic [ELEM_W-1:0]  head;
        logic               empty;
    } queue_res_t;

    logic clk;
    logic rst_n;

    cdlq_req_if req_ch ();
    cdlq_rsp_if rsp_ch ();

    circular_doubly_linked_queue_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    always #5 clk = ~clk;

    // Linked-list image kept by the predictor
    logic [ELEM_W-1:0]  succ    [N_ELEMS];
    logic [ELEM_W-1:0]  pred    [N_ELEMS];
    logic               in_list [N_ELEMS];
    logic [QSEL_W-1:0]  owner   [N_ELEMS];
    logic [ELEM_W-1:0]  q_head  [N_QUEUES];
    logic [COUNT_W-1:0] q_len   [N_QUEUES];

    // Membership as seen while building stimulus
    int gen_owner [N_ELEMS];

    queue_req_t op_requests[$];
    queue_res_t queue_op_results[$];

    int total_ops;
    int reqs_accepted;
    int results_seen;
    int mismatches;
    int stall_cycles;

    // Apply one request to the list image and return the expected transaction
    task automatic apply_queue_op(input logic cmd, input logic [QSEL_W-1:0] q,
                                  input logic [ELEM_W-1:0] e, output queue_res_t r);
        logic [ELEM_W-1:0] h;
        logic [ELEM_W-1:0] t;
        logic [ELEM_W-1:0] n;
        logic [ELEM_W-1:0] p;
        status_t           st;
        r = '0;
        r.elem = e;
        if (q >= N_QUEUES)
        begin
            r.status = ST_EMPTY;
            r.empty  = 1'b1;
        end
        else
        begin
            if (cmd == CMD_APPEND)
            begin
                if (e >= N_ELEMS || in_list[e])
                begin
                    st = ST_ALREADY;
                end
                else
                begin
                    if (q_len[q] == 0)
                    begin
                        succ[e]   = e;
                        pred[e]   = e;
                        q_head[q] = e;
                    end
                    else
                    begin
                        // link in just before the head
                        h       = q_head[q];
                        t       = pred[h];
                        pred[e] = t;
                        succ[t] = e;
                        succ[e] = h;
                        pred[h] = e;
                    end
                    in_list[e] = 1'b1;
                    owner[e]   = q;
                    q_len[q]   = q_len[q] + 1'b1;
                    st         = ST_OK;
                end
            end
            else
            begin
                if (q_len[q] == 0)
                begin
                    st = ST_EMPTY;
                end
                else if (e >= N_ELEMS || !in_list[e] || owner[e] != q)
                begin
                    st = ST_NOT_IN;
                end
                else
                begin
                    if (q_len[q] != 1)
                    begin
                        n       = succ[e];
                        p       = pred[e];
                        pred[n] = p;
                        succ[p] = n;
                        if (q_head[q] == e)
                            q_head[q] = n;
                    end
                    in_list[e] = 1'b0;
                    q_len[q]   = q_len[q] - 1'b1;
                    st         = ST_OK;
                end
            end
            r.status = st;
            r.count  = q_len[q];
            r.head   = (q_len[q] != 0) ? q_head[q] : '0;
            r.empty  = (q_len[q] == 0);
        end
    endtask

    // Queue a request and track membership for later picks
    task automatic queue_op(input logic cmd, input int q, input int e);
        queue_req_t rq;
        rq.cmd  = cmd;
        rq.qsel = QSEL_W'(q);
        rq.elem = ELEM_W'(e);
        op_requests.push_back(rq);
        if (cmd == CMD_APPEND && gen_owner[e] < 0)
            gen_owner[e] = q;
        else if (cmd == CMD_REMOVE && gen_owner[e] == q)
            gen_owner[e] = -1;
    endtask

    function automatic int pick_free();
        int start;
        int idx;
        start = $urandom_range(0, N_ELEMS - 1);
        for (int i = 0; i < N_ELEMS; i++)
        begin
            idx = (start + i) % N_ELEMS;
            if (gen_owner[idx] < 0)
                return idx;
        end
        return -1;
    endfunction

    // q < 0 picks a member of any queue
    function automatic int pick_member(input int q);
        int start;
        int idx;
        start = $urandom_range(0, N_ELEMS - 1);
        for (int i = 0; i < N_ELEMS; i++)
        begin
            idx = (start + i) % N_ELEMS;
            if (gen_owner[idx] >= 0 && (q < 0 || gen_owner[idx] == q))
                return idx;
        end
        return -1;
    endfunction

    // Four equal phases: none, sender idle, receiver stall, both
    function automatic int phase_of(input int n);
        int ph;
        if (total_ops == 0)
            return 0;
        ph = (n * 4) / total_ops;
        return (ph > 3) ? 3 : ph;
    endfunction

    function automatic bit send_idle();
        int ph;
        ph = phase_of(reqs_accepted);
        if (ph == 1)
            return $urandom_range(0, 99) < 60;
        if (ph == 3)
            return $urandom_range(0, 99) < 27;
        return 1'b0;
    endfunction

    function automatic bit recv_stall();
        int ph;
        ph = phase_of(results_seen);
        if (ph == 2)
            return $urandom_range(0, 99) < 60;
        if (ph == 3)
            return $urandom_range(0, 99) < 27;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input queue_res_t want);
        mismatches++;
        if (mismatches <= MAX_REPORT)
        begin
            $display("%0t mismatch (%s): exp st=%0d el=%0d cnt=%0d hd=%0d emp=%0d",
                     $realtime, what, want.status, want.elem, want.count, want.head,
                     want.empty);
            $display("    got st=%0d el=%0d cnt=%0d hd=%0d emp=%0d",
                     rsp_ch.status, rsp_ch.elem_out, rsp_ch.queue_count, rsp_ch.head_out,
                     rsp_ch.queue_empty);
        end
    endtask

    // Request driver; predicts each transaction as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        queue_res_t res;
        queue_req_t rq;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= CMD_APPEND;
            req_ch.queue_sel <= '0;
            req_ch.elem_id   <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_queue_op(req_ch.cmd, req_ch.queue_sel, req_ch.elem_id, res);
                queue_op_results.push_back(res);
                reqs_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (op_requests.size() > 0 && !send_idle())
                begin
                    rq = op_requests.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.cmd       <= rq.cmd;
                    req_ch.queue_sel <= rq.qsel;
                    req_ch.elem_id   <= rq.elem;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        queue_res_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (queue_op_results.size() == 0)
                begin
                    report_mismatch("unexpected", '0);
                end
                else
                begin
                    want = queue_op_results.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.elem_out !== want.elem ||
                        rsp_ch.queue_count !== want.count || rsp_ch.head_out !== want.head ||
                        rsp_ch.queue_empty !== want.empty)
                        report_mismatch("field", want);
                end
            end
            rsp_ch.ready <= !recv_stall();
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int  focus_q;
        int  fill_mode;
        int  q;
        int  e;
        int  roll;
        bit  want_append;
        int  append_pct [4];

        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_APPEND;
        req_ch.queue_sel = '0;
        req_ch.elem_id   = '0;
        rsp_ch.ready     = 1'b0;
        total_ops        = 0;
        reqs_accepted    = 0;
        results_seen     = 0;
        mismatches       = 0;
        focus_q          = 0;
        fill_mode        = 0;
        append_pct       = '{30, 55, 75, 90};

        for (int i = 0; i < N_ELEMS; i++)
        begin
            succ[i]      = '0;
            pred[i]      = '0;
            in_list[i]   = 1'b0;
            owner[i]     = '0;
            gen_owner[i] = -1;
        end
        for (int i = 0; i < N_QUEUES; i++)
        begin
            q_head[i] = '0;
            q_len[i]  = '0;
        end

        // Directed: empty remove, duplicates, foreign and absent removes,
        // head, tail, middle and last-element removal, extreme ids and queues
        queue_op(CMD_REMOVE, 0, 5);
        queue_op(CMD_APPEND, 0, 0);
        queue_op(CMD_APPEND, 0, 63);
        queue_op(CMD_APPEND, 0, 0);
        queue_op(CMD_APPEND, 3, 0);
        queue_op(CMD_APPEND, 3, 21);
        queue_op(CMD_REMOVE, 3, 0);
        queue_op(CMD_REMOVE, 0, 42);
        queue_op(CMD_APPEND, 0, 42);
        queue_op(CMD_REMOVE, 0, 0);
        queue_op(CMD_REMOVE, 0, 42);
        queue_op(CMD_REMOVE, 0, 63);
        queue_op(CMD_REMOVE, 0, 63);
        queue_op(CMD_APPEND, 1, 1);
        queue_op(CMD_APPEND, 1, 2);
        queue_op(CMD_APPEND, 1, 3);
        queue_op(CMD_REMOVE, 1, 2);
        queue_op(CMD_REMOVE, 1, 1);
        queue_op(CMD_REMOVE, 1, 3);
        queue_op(CMD_APPEND, 2, 62);
        queue_op(CMD_APPEND, 2, 31);
        queue_op(CMD_REMOVE, 2, 31);
        queue_op(CMD_REMOVE, 2, 62);

        // Random: mostly legal appends and removes, biased in stretches to
        // fill or drain one queue, with some unconstrained requests mixed in
        for (int i = 0; i < RAND_OPS; i++)
        begin
            if (i % 150 == 0)
            begin
                focus_q   = $urandom_range(0, N_QUEUES - 1);
                fill_mode = $urandom_range(0, 3);
            end
            q    = (fill_mode == 3 || $urandom_range(0, 1)) ? focus_q
                                                            : $urandom_range(0, N_QUEUES - 1);
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                queue_op(1'($urandom_range(0, 1)), $urandom_range(0, N_QUEUES - 1),
                         $urandom_range(0, N_ELEMS - 1));
            end
            else
            begin
                want_append = $urandom_range(0, 99) < append_pct[fill_mode];
                e = want_append ? pick_free() : -1;
                if (e >= 0)
                begin
                    queue_op(CMD_APPEND, q, e);
                end
                else
                begin
                    e = pick_member(q);
                    if (e < 0)
                    begin
                        e = pick_member(-1);
                        if (e >= 0)
                            q = gen_owner[e];
                    end
                    if (e >= 0)
                        queue_op(CMD_REMOVE, q, e);
                    else
                        queue_op(CMD_APPEND, q, $urandom_range(0, N_ELEMS - 1));
                end
            end
        end
        total_ops = op_requests.size();

        // Reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain
        while (op_requests.size() != 0 || req_ch.valid)
            @(negedge clk);
        while (queue_op_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
